// ===== design/lirs_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
// No dependencies; imported by the controller, datapath and top level.
package lirs_pkg;

   localparam int NUM_CH       = 8;    // sample ports per beat
   localparam int SAMPLE_W     = 8;
   localparam int POS_W        = 48;   // output position accumulator
   localparam int CNT_W        = 32;   // frame and output counters
   localparam int CFG_W        = 32;
   localparam int CSR_IDX_W    = 8;
   localparam int MAX_RESULTS  = 64;   // results per input beat
   localparam int DEF_LANES    = 8;
   localparam int DEF_FRAC_BITS = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_STEP  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = CSR_IDX_W'(1);

   // controller -> datapath
   typedef struct packed {
      logic load;      // latch input beat
      logic emit;      // load output register, advance position
      logic last_out;  // tag emitted beat as last of this step
      logic finish;    // retire input beat, commit frame state
   } lirs_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic go;        // an output is due now
      logic go_next;   // another output is due after the current one
   } lirs_sts_type;

endpackage

// ===== design/lirs_ctrl.sv =====
// Sequencing controller for the resampler: input/output handshake and result count.
// Depends on lirs_pkg.
module lirs_ctrl
   import lirs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  lirs_sts_type sts,
   output lirs_cmd_type cmd
);

   localparam int N_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type      state_ff, state_in;
   logic [N_W-1:0] n_ff, n_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [N_W:0]   n_plus1;
   logic           go_all, go_next_all, slot_free;

   assign n_plus1     = {1'b0, n_ff} + (N_W+1)'(1);
   assign go_all      = sts.go && ({1'b0, n_ff} < (N_W+1)'(MAX_RESULTS));
   assign go_next_all = sts.go_next && (n_plus1 < (N_W+1)'(MAX_RESULTS));
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               n_in     = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!go_all) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else if (slot_free) begin
               cmd.emit     = 1'b1;
               cmd.last_out = !go_next_all;
               n_in         = n_plus1[N_W-1:0];
               if (!go_next_all) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_emit_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !cmd.emit)
      else $error("emit while idle");

   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      {1'b0, n_ff} <= (N_W+1)'(MAX_RESULTS))
      else $error("result count exceeds cap");

   a_finish_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req_ready)
      else $error("not ready after retiring a beat");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.emit)
      else $error("pending result overwritten");

endmodule

// ===== design/lirs_datapath.sv =====
// Resampler datapath: config registers, frame and position state, per-lane lerp,
// output register. Depends on lirs_pkg.
module lirs_datapath
   import lirs_pkg::*;
#(
   parameter int LANES     = DEF_LANES,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_wdata,
   input  logic signed [SAMPLE_W-1:0] in_sample [NUM_CH],
   input  logic                       in_last,
   input  lirs_cmd_type               cmd,
   output lirs_sts_type               sts,
   output logic signed [SAMPLE_W-1:0] out_value [NUM_CH],
   output logic                       out_last
);

   localparam int IP_W = POS_W - FRAC_BITS;
   localparam int NUM_W = FRAC_BITS + 11;
   localparam int PROD_W = FRAC_BITS + SAMPLE_W + 2;

   logic [CFG_W-1:0] step_ff, count_ff;
   logic [POS_W-1:0] pos_ff, pos_next;
   logic [CNT_W-1:0] frames_ff, done_ff;
   logic [CNT_W:0]   done_plus1;
   logic             last_ff;
   logic [IP_W-1:0]  ip, ip_next;
   logic [FRAC_BITS-1:0] frac;
   logic             interp;
   logic [POS_W-1:0] frames_ext;

   logic signed [SAMPLE_W-1:0] prev_ff [LANES];
   logic signed [SAMPLE_W-1:0] cur_ff  [LANES];
   logic signed [SAMPLE_W-1:0] lane_val [LANES];
   logic signed [SAMPLE_W-1:0] value_ff [NUM_CH];
   logic                       out_last_ff;

   assign pos_next   = pos_ff + POS_W'(step_ff);
   assign ip         = pos_ff[POS_W-1:FRAC_BITS];
   assign ip_next    = pos_next[POS_W-1:FRAC_BITS];
   assign frac       = pos_ff[FRAC_BITS-1:0];
   assign frames_ext = POS_W'(frames_ff);
   assign interp     = POS_W'(ip) < frames_ext;
   assign done_plus1 = {1'b0, done_ff} + (CNT_W+1)'(1);

   assign sts.go      = (done_ff < count_ff) && (interp || last_ff);
   assign sts.go_next = (done_plus1 < {1'b0, count_ff})
                        && ((POS_W'(ip_next) < frames_ext) || last_ff);

   // one interpolator per lane, rounded half away from zero
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic signed [SAMPLE_W:0]          diff;
      logic signed [FRAC_BITS:0]         frac_s;
      logic signed [PROD_W-1:0]          prod;
      logic signed [NUM_W-1:0]           num;
      logic [NUM_W-1:0]                  mag, rnd;
      logic [SAMPLE_W-1:0]               r;

      assign diff   = (SAMPLE_W+1)'(cur_ff[g]) - (SAMPLE_W+1)'(prev_ff[g]);
      assign frac_s = {1'b0, frac};
      assign prod   = PROD_W'(frac_s) * PROD_W'(diff);
      assign num    = (NUM_W'(prev_ff[g]) <<< FRAC_BITS) + NUM_W'(prod);
      assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      assign rnd    = mag + (NUM_W'(1) << (FRAC_BITS - 1));
      assign r      = rnd[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
      assign lane_val[g] = !interp ? cur_ff[g]
                         : (num[NUM_W-1] ? SAMPLE_W'(-r) : SAMPLE_W'(r));

      always_ff @(posedge clock) begin
         if (cmd.load) begin
            cur_ff[g] <= in_sample[g];
         end
         if (reset || (cmd.finish && last_ff)) begin
            prev_ff[g] <= '0;
         end else if (cmd.finish) begin
            prev_ff[g] <= cur_ff[g];
         end
      end
   end

   for (genvar g = 0; g < NUM_CH; g++) begin : g_out
      if (g < LANES) begin : g_live
         always_ff @(posedge clock) begin
            if (cmd.emit) begin
               value_ff[g] <= lane_val[g];
            end
         end
      end else begin : g_dead
         assign value_ff[g] = '0;
      end
      assign out_value[g] = value_ff[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= CFG_W'(1) << FRAC_BITS;
         count_ff  <= '0;
         pos_ff    <= '0;
         frames_ff <= '0;
         done_ff   <= '0;
         last_ff   <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == CSR_STEP)) begin
            step_ff <= csr_wdata;
         end
         if (csr_valid && (csr_index == CSR_COUNT)) begin
            count_ff <= csr_wdata;
         end
         if (cmd.load) begin
            last_ff <= in_last;
         end
         if (cmd.finish && last_ff) begin
            pos_ff    <= '0;
            done_ff   <= '0;
            frames_ff <= '0;
         end else begin
            if (cmd.emit) begin
               pos_ff  <= pos_next;
               done_ff <= done_plus1[CNT_W-1:0];
            end
            if (cmd.finish) begin
               frames_ff <= frames_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_last_ff <= cmd.last_out;
      end
   end

   assign out_last = out_last_ff;

endmodule

// ===== design/linear_interp_resampler_top.sv =====
// Top level of the linear interpolation resampler: ports, lane packing.
// Depends on lirs_pkg, lirs_ctrl and lirs_datapath.
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_ready  req_sample_0..7, req_last_frame
//  rsp       out        rsp_valid/rsp_ready  rsp_value_0..7, rsp_last_of_run
//  csr       in         csr_valid/csr_ready  csr_index, csr_wdata
//
// An input beat yields k results (0..64): it is accepted in ST_IDLE, then the
// single interpolator per lane gives one result per cycle while the output
// slot is free, the last result also retiring the beat; with k = 0 it just retires.
// Reset is synchronous, active high; it restores step to 1.0, count to 0 and
// clears all run state. A stalled result holds the output register and pauses
// the result sequence; csr_ready is always high.
module linear_interp_resampler_top
   import lirs_pkg::*;
#(
   parameter int LANES     = DEF_LANES,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample_0,
   input  logic signed [SAMPLE_W-1:0] req_sample_1,
   input  logic signed [SAMPLE_W-1:0] req_sample_2,
   input  logic signed [SAMPLE_W-1:0] req_sample_3,
   input  logic signed [SAMPLE_W-1:0] req_sample_4,
   input  logic signed [SAMPLE_W-1:0] req_sample_5,
   input  logic signed [SAMPLE_W-1:0] req_sample_6,
   input  logic signed [SAMPLE_W-1:0] req_sample_7,
   input  logic                       req_last_frame,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_value_0,
   output logic signed [SAMPLE_W-1:0] rsp_value_1,
   output logic signed [SAMPLE_W-1:0] rsp_value_2,
   output logic signed [SAMPLE_W-1:0] rsp_value_3,
   output logic signed [SAMPLE_W-1:0] rsp_value_4,
   output logic signed [SAMPLE_W-1:0] rsp_value_5,
   output logic signed [SAMPLE_W-1:0] rsp_value_6,
   output logic signed [SAMPLE_W-1:0] rsp_value_7,
   output logic                       rsp_last_of_run,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_wdata
);

   lirs_cmd_type               cmd;
   lirs_sts_type               sts;
   logic signed [SAMPLE_W-1:0] in_sample [NUM_CH];
   logic signed [SAMPLE_W-1:0] out_value [NUM_CH];

   // config writes go straight into the registers, never back-pressure
   assign csr_ready = 1'b1;

   // pack the sample ports into lanes
   assign in_sample[0] = req_sample_0;
   assign in_sample[1] = req_sample_1;
   assign in_sample[2] = req_sample_2;
   assign in_sample[3] = req_sample_3;
   assign in_sample[4] = req_sample_4;
   assign in_sample[5] = req_sample_5;
   assign in_sample[6] = req_sample_6;
   assign in_sample[7] = req_sample_7;

   lirs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lirs_datapath #(
      .LANES     (LANES),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_sample (in_sample),
      .in_last   (req_last_frame),
      .cmd       (cmd),
      .sts       (sts),
      .out_value (out_value),
      .out_last  (rsp_last_of_run)
   );

   // unpack lanes; lanes at or above LANES read as zero
   assign rsp_value_0 = out_value[0];
   assign rsp_value_1 = out_value[1];
   assign rsp_value_2 = out_value[2];
   assign rsp_value_3 = out_value[3];
   assign rsp_value_4 = out_value[4];
   assign rsp_value_5 = out_value[5];
   assign rsp_value_6 = out_value[6];
   assign rsp_value_7 = out_value[7];

endmodule

// ===== tb/tb_linear_interp_resampler_top.sv =====
// Self-checking testbench for linear_interp_resampler_top: directed and random frames
// with a built-in interpolation predictor and a beat-by-beat result scoreboard.
// Depends on lirs_pkg and the resampler RTL only.
`timescale 1ns / 100ps

module tb_linear_interp_resampler_top;
   import lirs_pkg::*;

   localparam int LANES          = DEF_LANES;
   localparam int FRAC_BITS      = DEF_FRAC_BITS;
   localparam int TOTAL_ITEMS    = 430;
   localparam int SETTLE_CYCLES  = 16;    // a beat with no results is still accepted and retired inside the block
   localparam int LONG_STALL     = 400;
   localparam int WATCHDOG_LIMIT = 3000;

   // One frame of lanes plus its marker; used for input beats and result beats alike
   typedef struct packed {
      logic                            last;
      logic [NUM_CH-1:0][SAMPLE_W-1:0] lane;
   } frame_t;

   // ---------------------------------------------------------------------------------
   // Clock, reset and block ports
   // ---------------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [NUM_CH-1:0][SAMPLE_W-1:0] req_lane  = '0;
   logic                            req_last  = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   wire  [NUM_CH-1:0][SAMPLE_W-1:0] rsp_lane;
   wire                             rsp_last;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [CSR_IDX_W-1:0]            csr_index = '0;
   logic [CFG_W-1:0]                csr_wdata = '0;

   linear_interp_resampler_top #(
      .LANES     (LANES),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_0    (req_lane[0]),
      .req_sample_1    (req_lane[1]),
      .req_sample_2    (req_lane[2]),
      .req_sample_3    (req_lane[3]),
      .req_sample_4    (req_lane[4]),
      .req_sample_5    (req_lane[5]),
      .req_sample_6    (req_lane[6]),
      .req_sample_7    (req_lane[7]),
      .req_last_frame  (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value_0     (rsp_lane[0]),
      .rsp_value_1     (rsp_lane[1]),
      .rsp_value_2     (rsp_lane[2]),
      .rsp_value_3     (rsp_lane[3]),
      .rsp_value_4     (rsp_lane[4]),
      .rsp_value_5     (rsp_lane[5]),
      .rsp_value_6     (rsp_lane[6]),
      .rsp_value_7     (rsp_lane[7]),
      .rsp_last_of_run (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------------------------
   frame_t frames_to_send[$];     // input beats waiting for the driver
   frame_t due_frames[$];         // predicted result beats, oldest first
   int     items_queued      = 0;
   int     error_count       = 0;
   bit     no_idle           = 1'b0;  // both sides run back to back while set
   int     long_stalls_asked = 0;     // bumped by the sequence, served by the receiver
   int     long_stalls_done  = 0;

   // Predictor copy of the registers and the run state
   logic [CFG_W-1:0]                step_cfg     = CFG_W'(1 << FRAC_BITS);
   logic [CFG_W-1:0]                count_cfg    = '0;
   logic [NUM_CH-1:0][SAMPLE_W-1:0] prev_lane    = '0;
   logic [POS_W-1:0]                out_pos      = '0;
   logic [CNT_W-1:0]                frames_seen  = '0;
   logic [CNT_W-1:0]                outputs_done = '0;

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   // v1 + frac*(v2-v1), rounded half away from zero
   function automatic logic [SAMPLE_W-1:0] lerp_lane(input logic signed [SAMPLE_W-1:0] v1,
                                                     input logic signed [SAMPLE_W-1:0] v2,
                                                     input logic [FRAC_BITS-1:0] frac);
      longint num;
      longint half;
      half = longint'(1) <<< (FRAC_BITS - 1);
      num  = (longint'(v1) <<< FRAC_BITS) + longint'(frac) * (longint'(v2) - longint'(v1));
      if (num >= 0)
         return SAMPLE_W'((num + half) >>> FRAC_BITS);
      return SAMPLE_W'(-((-num + half) >>> FRAC_BITS));
   endfunction

   // Work out every result beat one accepted input frame causes and queue them
   function automatic void predict_outputs(input frame_t fr);
      logic [NUM_CH-1:0][SAMPLE_W-1:0] cur;
      logic [POS_W-1:0]                ipart;
      frame_t                          out_frame;
      frame_t                          held;
      bit                              have_held;
      bit                              interp;
      int                              n;
      cur       = '0;
      held      = '0;
      have_held = 1'b0;
      n         = 0;
      for (int i = 0; i < LANES; i++)
         cur[i] = fr.lane[i];

      while (n < MAX_RESULTS && outputs_done < count_cfg) begin
         ipart = out_pos >> FRAC_BITS;
         // interpolate while the position lies behind the newest frame; on the
         // closing frame the rest holds that frame; otherwise wait for more input
         if (ipart < POS_W'(frames_seen))
            interp = 1'b1;
         else if (fr.last)
            interp = 1'b0;
         else
            break;
         out_frame = '0;
         for (int i = 0; i < LANES; i++)
            out_frame.lane[i] = interp ?
               lerp_lane(prev_lane[i], cur[i], out_pos[FRAC_BITS-1:0]) : cur[i];
         // hold back one beat so the final one of this step can be tagged
         if (have_held)
            due_frames.push_back(held);
         held      = out_frame;
         have_held = 1'b1;
         n++;
         outputs_done++;
         out_pos += POS_W'(step_cfg);
      end
      if (have_held) begin
         held.last = 1'b1;
         due_frames.push_back(held);
      end

      if (fr.last) begin
         prev_lane    = '0;
         out_pos      = '0;
         frames_seen  = '0;
         outputs_done = '0;
      end else begin
         prev_lane = cur;
         frames_seen++;
      end
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("[%0t] %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------------------
   // Input driver: present queued frames, predict on each accepted beat
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_frames
      frame_t nxt;
      int     send_gap;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            predict_outputs({req_last, req_lane});
         // change the payload only when nothing is on offer or it was just taken
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (frames_to_send.size() != 0) begin
               nxt = frames_to_send.pop_front();
               req_lane  <= nxt.lane;
               req_last  <= nxt.last;
               req_valid <= 1'b1;
               send_gap = no_idle ? 0 : idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver backpressure: random stalls plus an occasional long hold-off
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_ready
      int stall_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (long_stalls_done != long_stalls_asked && stall_left == 0) begin
         // hold off long enough for the block to fill and stall its input
         long_stalls_done++;
         stall_left = LONG_STALL;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (no_idle) begin
         rsp_ready <= 1'b1;
      end else begin
         stall_left = idle_len();
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   // ---------------------------------------------------------------------------------
   // Result monitor: compare each accepted beat against the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      frame_t got;
      frame_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_last, rsp_lane};
         if (due_frames.size() == 0) begin
            flag_error($sformatf("result beat with nothing expected: lanes %h last %b",
                                 got.lane, got.last));
         end else begin
            want = due_frames.pop_front();
            for (int i = 0; i < NUM_CH; i++)
               if (got.lane[i] !== want.lane[i])
                  flag_error($sformatf("value_%0d: expected %0d, got %0d", i,
                                       $signed(want.lane[i]), $signed(got.lane[i])));
            if (got.last !== want.last)
               flag_error($sformatf("last_of_run: expected %b, got %b", want.last, got.last));
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Watchdog: end the run once nothing has moved on any channel for too long
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, due_frames.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequence helpers
   // ---------------------------------------------------------------------------------

   // Write one register; mirror it into the predictor on the accepting edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_STEP)
         step_cfg = val;
      else if (idx == CSR_COUNT)
         count_cfg = val;
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] count);
      write_reg(CSR_STEP, step);
      write_reg(CSR_COUNT, count);
   endtask

   // Wait until every frame is taken and every result is back, then let the block settle.
   // Check on the falling edge so all updates of the rising edge are visible.
   task automatic wait_drained();
      do @(negedge clock);
      while (frames_to_send.size() != 0 || req_valid || due_frames.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_frame(input bit last, input logic [NUM_CH-1:0][SAMPLE_W-1:0] lanes);
      frames_to_send.push_back({last, lanes});
      items_queued++;
   endtask

   task automatic queue_random_frame(input bit last);
      logic [NUM_CH-1:0][SAMPLE_W-1:0] lanes;
      lanes = {$urandom, $urandom};
      // now and then a frame of full-scale samples
      if ($urandom_range(0, 9) == 0)
         for (int i = 0; i < NUM_CH; i++)
            lanes[i] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
      queue_frame(last, lanes);
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin : sequence_main
      logic [CFG_W-1:0] step;
      logic [CFG_W-1:0] count;
      int               phase;
      int               phase_items;
      int               k;
      int               len;
      int               r;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // A lone closing frame: every output holds that frame
      set_config(32'h0001_0000, 32'd3);
      queue_frame(1'b1, 64'h80_7F_00_FF_01_80_7F_55);
      wait_drained();

      // Half steps: exact halves round away from zero; closing frame caps at the
      // result limit and drops the rest of a huge count
      set_config(32'h0000_8000, 32'hFFFF_FFFF);
      queue_frame(1'b0, 64'h00_00_00_00_00_00_00_00);
      queue_frame(1'b0, 64'h80_7F_FD_03_80_7F_FF_01);
      queue_frame(1'b0, 64'h7F_80_00_00_7F_80_00_00);
      queue_frame(1'b1, 64'h80_80_7F_7F_80_7F_80_7F);
      wait_drained();

      // Zero step: outputs pile up at one position, excess carries to later frames,
      // then the count runs out and further frames are only kept
      set_config(32'h0000_0000, 32'd100);
      queue_frame(1'b0, 64'h7F_7F_7F_7F_80_80_80_80);
      queue_frame(1'b0, 64'h80_80_80_80_7F_7F_7F_7F);
      queue_frame(1'b0, 64'h01_FF_40_C0_20_E0_10_F0);
      queue_frame(1'b0, 64'h11_22_33_44_55_66_77_08);
      queue_frame(1'b1, 64'hFF_EE_DD_CC_BB_AA_99_88);
      wait_drained();

      // Largest step: one interpolated output, the rest held on the closing frame
      set_config(32'hFFFF_FFFF, 32'd5);
      queue_frame(1'b0, 64'h12_34_56_78_9A_BC_DE_F0);
      queue_frame(1'b0, 64'h7F_80_7F_80_7F_80_7F_80);
      queue_frame(1'b0, 64'h00_FF_00_FF_00_FF_00_FF);
      queue_frame(1'b1, 64'h80_7F_80_7F_80_7F_80_7F);
      wait_drained();

      // Smallest regular step
      set_config(32'h0000_0800, 32'd40);
      queue_frame(1'b0, 64'h80_80_80_80_80_80_80_80);
      queue_frame(1'b0, 64'h7F_7F_7F_7F_7F_7F_7F_7F);
      queue_frame(1'b1, 64'h00_01_02_03_FC_FD_FE_FF);
      wait_drained();

      // Random phases: new settings each phase, mostly well-formed runs
      phase = 0;
      while (items_queued < TOTAL_ITEMS) begin
         phase++;
         r = $urandom_range(0, 99);
         if (r < 5)
            step = 32'h0000_0800;
         else if (r < 10)
            step = 32'hFFFF_FFFF;
         else if (r < 15)
            step = $urandom_range(0, 1023);
         else if (r < 20)
            step = $urandom;
         else
            step = $urandom_range(8192, 262144);
         r = $urandom_range(0, 99);
         if (r < 10)
            count = '0;
         else if (r < 20)
            count = 32'hFFFF_FFFF;
         else
            count = $urandom_range(1, 120);

         wait_drained();
         // a long hold-off needs results to back the block up
         if (phase == 2 || phase == 7) begin
            if (count == '0)
               count = 32'd60;
            long_stalls_asked++;
         end
         set_config(step, count);
         no_idle = (phase % 4 == 0);

         phase_items = $urandom_range(25, 45);
         k = 0;
         while (k < phase_items) begin
            if ($urandom_range(0, 99) < 85) begin
               len = $urandom_range(1, 10);
               for (int j = 0; j < len; j++)
                  queue_random_frame(j == len - 1);
            end else begin
               // broken run: stray closing markers or none at all
               len = $urandom_range(1, 6);
               for (int j = 0; j < len; j++)
                  queue_random_frame($urandom_range(0, 3) == 0);
            end
            k += len;
            // pause the sender mid-phase until every result is back
            if (k == len && phase % 5 == 3)
               wait_drained();
         end
      end

      wait_drained();
      if (error_count == 0 && due_frames.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/lirs_pkg.sv
design/lirs_ctrl.sv
design/lirs_datapath.sv
design/linear_interp_resampler_top.sv
tb/tb_linear_interp_resampler_top.sv
